### rtl/core/dlp_pkg.sv
`timescale 1ns / 1ps

package dlp_pkg;

    localparam int CHAR_W = 8;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_END   = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_EOL   = 8'h9B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

endpackage

### rtl/core/dlp_line_buf.sv
`timescale 1ns / 1ps

module dlp_line_buf #(
    parameter int DEPTH  = 23,
    parameter int ADDR_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [dlp_pkg::CHAR_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [dlp_pkg::CHAR_W-1:0]  o_rdata
);

    logic [dlp_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [dlp_pkg::CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/directory_listing_line_parser_core.sv
`timescale 1ns / 1ps

// directory listing line parser
// input channel (i_in_valid / o_in_ready) takes one item per opcode: a listing
// byte, an end-of-listing flush or a start of a new listing. bytes go into an
// on-chip line buffer of NAME_LEN-1 entries; extra bytes of a line are dropped.
// a line end that yields an entry emits the first word of the line, less a
// trailing slash, on the output channel (o_out_valid / i_out_ready), one item
// per name character, each with the entry index and directory flag, and a last marker on the final one.
// byte and start items leave the parser idle, so the input stays ready. a line
// end that emits a name holds the input until the final character is loaded:
// each character takes a registered buffer read (ST_READ), then a load of the
// output register (ST_LOAD). a lone slash gives a single item with no valid character.
// the output register lets the next input item be taken while the final
// character of a name still waits; when the receiver stalls, the character
// sequencer holds and no input is taken until the final character is loaded.
// reset (synchronous, active low) clears the line length, the entry count and
// the output valid; buffer contents are left as they are.

module directory_listing_line_parser_core #(
    parameter int MAX_ENTRIES = 48,
    parameter int NAME_LEN    = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_entry_index,
    output logic [4:0] o_char_pos,
    output logic [7:0] o_name_char,
    output logic       o_char_valid,
    output logic       o_is_directory,
    output logic       o_last
);

    localparam int BUF_DEPTH = NAME_LEN - 1;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LEN_W     = $clog2(NAME_LEN);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);

    dlp_pkg::t_state r_state, n_state;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_sp_seen, n_sp_seen;
    logic [LEN_W-1:0] r_sp_idx, n_sp_idx;
    logic             r_slash, n_slash;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_k, n_k;
    logic [LEN_W-1:0] r_last_k, n_last_k;
    logic             r_dir, n_dir;
    logic             r_lone, n_lone;
    logic [5:0]       r_entry, n_entry;
    logic             r_out_valid, n_out_valid;

    logic [5:0] r_o_entry;
    logic [4:0] r_o_pos;
    logic [7:0] r_o_char;
    logic       r_o_cvalid;
    logic       r_o_dir;
    logic       r_o_last;

    logic                 w_accept;
    dlp_pkg::t_opcode     w_op;
    logic                 w_term;
    logic                 w_line_end;
    logic [LEN_W-1:0]     w_nlen;
    logic [LEN_W-1:0]     w_nlen2;
    logic                 w_emit;
    logic                 w_we;
    logic                 w_load;
    logic                 w_is_last;
    logic [7:0]           w_rdata;
    logic [CNT_W+5:0]     w_cnt_ext;
    logic [LEN_W+4:0]     w_k_ext;

    assign o_in_ready = (r_state == dlp_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_op       = dlp_pkg::t_opcode'(i_opcode);

    assign w_term = (i_data_byte == dlp_pkg::CH_CR) || (i_data_byte == dlp_pkg::CH_LF) ||
                    (i_data_byte == dlp_pkg::CH_NUL) || (i_data_byte == dlp_pkg::CH_EOL);
    assign w_line_end = (w_op == dlp_pkg::OP_END) || ((w_op == dlp_pkg::OP_BYTE) && w_term);

    // first word ends at the first space, or at the line end
    assign w_nlen  = r_sp_seen ? r_sp_idx : r_len;
    assign w_nlen2 = w_nlen - LEN_W'(r_slash);
    assign w_emit  = (r_len != '0) && (w_nlen != '0) && (r_count < CNT_W'(MAX_ENTRIES));

    assign w_we = w_accept && (w_op == dlp_pkg::OP_BYTE) && !w_term &&
                  (r_len < LEN_W'(BUF_DEPTH));

    assign w_load    = (r_state == dlp_pkg::ST_LOAD) && (!r_out_valid || i_out_ready);
    assign w_is_last = r_lone || (r_k == r_last_k);

    assign w_cnt_ext = (CNT_W + 6)'(r_count);
    assign w_k_ext   = (LEN_W + 5)'(r_k);

    dlp_line_buf #(
        .DEPTH  (BUF_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_sp_seen   = r_sp_seen;
        n_sp_idx    = r_sp_idx;
        n_slash     = r_slash;
        n_count     = r_count;
        n_k         = r_k;
        n_last_k    = r_last_k;
        n_dir       = r_dir;
        n_lone      = r_lone;
        n_entry     = r_entry;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            dlp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_op == dlp_pkg::OP_START) begin
                        n_count   = '0;
                        n_len     = '0;
                        n_sp_seen = 1'b0;
                        n_slash   = 1'b0;
                    end else if (w_line_end) begin
                        n_len     = '0;
                        n_sp_seen = 1'b0;
                        n_slash   = 1'b0;
                        if (w_emit) begin
                            n_count  = r_count + CNT_W'(1);
                            n_entry  = w_cnt_ext[5:0];
                            n_dir    = r_slash;
                            n_k      = '0;
                            n_last_k = w_nlen2 - LEN_W'(1);
                            n_lone   = (w_nlen2 == '0);
                            n_state  = (w_nlen2 == '0) ? dlp_pkg::ST_LOAD : dlp_pkg::ST_READ;
                        end
                    end else if (w_we) begin
                        n_len = r_len + LEN_W'(1);
                        if (!r_sp_seen) begin
                            if (i_data_byte == dlp_pkg::CH_SPACE) begin
                                n_sp_seen = 1'b1;
                                n_sp_idx  = r_len;
                            end else begin
                                n_slash = (i_data_byte == dlp_pkg::CH_SLASH);
                            end
                        end
                    end
                end
            end
            dlp_pkg::ST_READ: begin
                n_state = dlp_pkg::ST_LOAD;
            end
            dlp_pkg::ST_LOAD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    if (w_is_last) begin
                        n_state = dlp_pkg::ST_IDLE;
                    end else begin
                        n_k     = r_k + LEN_W'(1);
                        n_state = dlp_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = dlp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlp_pkg::ST_IDLE;
            r_len       <= '0;
            r_sp_seen   <= 1'b0;
            r_slash     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_sp_seen   <= n_sp_seen;
            r_slash     <= n_slash;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp_idx <= n_sp_idx;
        r_k      <= n_k;
        r_last_k <= n_last_k;
        r_dir    <= n_dir;
        r_lone   <= n_lone;
        r_entry  <= n_entry;
        if (w_load) begin
            r_o_entry  <= r_entry;
            r_o_pos    <= w_k_ext[4:0];
            r_o_char   <= r_lone ? 8'h00 : w_rdata;
            r_o_cvalid <= !r_lone;
            r_o_dir    <= r_dir;
            r_o_last   <= w_is_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_index  = r_o_entry;
    assign o_char_pos     = r_o_pos;
    assign o_name_char    = r_o_char;
    assign o_char_valid   = r_o_cvalid;
    assign o_is_directory = r_o_dir;
    assign o_last         = r_o_last;

endmodule
